/* rtl/tws_pkg.sv */
package tws_pkg;

	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 512;
	localparam int TILE          = 64;
	localparam int TEX_WIDTH     = 64;
	localparam int TEX_HEIGHT    = 64;
	localparam int WALL_SCALE    = 12;
	localparam logic [7:0] SHADE_ALPHA = 8'd200;

	localparam logic [63:0] KNUM = 64'(WALL_SCALE) * 64'(SCREEN_HEIGHT) * 64'd65536;
	localparam int QB  = $clog2(KNUM + 64'd1);
	localparam int SW  = QB + 1;
	localparam int H0  = SCREEN_HEIGHT * 256;
	localparam int DW  = 24;
	localparam int TXB = $clog2(TEX_WIDTH);
	localparam int TYB = $clog2(TEX_HEIGHT);
	localparam int SPB = $clog2(TILE) + 8;
	localparam int AW  = 2 + TXB + TYB;
	localparam int TEX_DEPTH  = 4 * TEX_WIDTH * TEX_HEIGHT;
	localparam int FACE_WORDS = TEX_WIDTH * TEX_HEIGHT;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_SHADE = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_CEILING = 1'b0,
		CFG_FLOOR   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REG_CEIL  = 2'd0,
		REG_WALL  = 2'd1,
		REG_FLOOR = 2'd2
	} region_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [1:0]      face;
		logic [11:0]     tidx;
		logic [31:0]     tval;
		logic [9:0]      col;
		logic [8:0]      row;
		logic [TXB-1:0]  tx;
	} meta_t;

	typedef struct packed {
		meta_t   m;
		region_t region;
		logic    onscr;
	} pix_t;

endpackage

/* rtl/tws_if.sv */
interface tws_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [1:0]  face;
	logic [11:0] texel_index;
	logic [31:0] texel_value;
	logic [9:0]  column;
	logic [8:0]  row;
	logic [23:0] hit_x;
	logic [23:0] hit_y;
	logic [23:0] distance;
	modport source (output valid, cmd, face, texel_index, texel_value, column, row,
		hit_x, hit_y, distance, input ready);
	modport sink (input valid, cmd, face, texel_index, texel_value, column, row,
		hit_x, hit_y, distance, output ready);
endinterface

interface tws_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [31:0] pixel_color;
	logic [1:0]  region;
	logic        drawn;
	modport source (output valid, pixel_x, pixel_y, pixel_color, region, drawn,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, region, drawn,
		output ready);
endinterface

/* rtl/tws_ram.sv */
module tws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

/* rtl/tws_recip.sv */
module tws_recip import tws_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [DW-1:0] d,
	input  meta_t         in_meta,
	output logic          out_valid,
	output logic [QB-1:0] h8,
	output meta_t         out_meta
);
	logic          v_q   [QB];
	meta_t         m_q   [QB];
	logic [DW-1:0] d_q   [QB];
	logic [DW-1:0] rem_q [QB];
	logic [QB-1:0] quo_q [QB];

	logic [DW:0]   t_c   [QB];
	logic          ge_c  [QB];
	logic [DW-1:0] ds_c  [QB];
	logic [DW-1:0] rem_c [QB];
	logic [QB-1:0] pq_c  [QB];
	logic [QB-1:0] quo_c [QB];

	always_comb begin
		ds_c[0] = d;
		t_c[0]  = {{DW{1'b0}}, KNUM[QB-1]};
		pq_c[0] = '0;
		for (int i = 1; i < QB; i++) begin
			ds_c[i] = d_q[i-1];
			t_c[i]  = {rem_q[i-1], KNUM[QB-1-i]};
			pq_c[i] = quo_q[i-1];
		end
		for (int i = 0; i < QB; i++) begin
			ge_c[i]  = t_c[i] >= {1'b0, ds_c[i]};
			rem_c[i] = ge_c[i] ? DW'(t_c[i] - {1'b0, ds_c[i]}) : t_c[i][DW-1:0];
			quo_c[i] = {pq_c[i][QB-2:0], ge_c[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < QB; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_q[0] <= in_meta;
			for (int i = 1; i < QB; i++) m_q[i] <= m_q[i-1];
			for (int i = 0; i < QB; i++) begin
				d_q[i]   <= ds_c[i];
				rem_q[i] <= rem_c[i];
				quo_q[i] <= quo_c[i];
			end
		end
	end

	assign out_valid = v_q[QB-1];
	assign out_meta  = m_q[QB-1];
	assign h8 = (d_q[QB-1] == '0) ? QB'(H0) : quo_q[QB-1];
endmodule

/* rtl/tws_texrow.sv */
module tws_texrow import tws_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  logic [SW-1:0]  num,
	input  logic [SW-1:0]  den,
	input  pix_t           in_pix,
	output logic           out_valid,
	output logic [TYB-1:0] ty,
	output logic           oor,
	output pix_t           out_pix
);
	logic           v_q   [TYB];
	pix_t           p_q   [TYB];
	logic           oor_q [TYB];
	logic [SW-1:0]  den_q [TYB];
	logic [SW-1:0]  rem_q [TYB];
	logic [TYB-1:0] quo_q [TYB];

	logic [SW:0]    t_c   [TYB];
	logic [SW-1:0]  dn_c  [TYB];
	logic           ge_c  [TYB];
	logic [SW-1:0]  rem_c [TYB];
	logic [TYB-1:0] pq_c  [TYB];

	always_comb begin
		dn_c[0] = den;
		t_c[0]  = {num, 1'b0};
		pq_c[0] = '0;
		for (int i = 1; i < TYB; i++) begin
			dn_c[i] = den_q[i-1];
			t_c[i]  = {rem_q[i-1], 1'b0};
			pq_c[i] = quo_q[i-1];
		end
		for (int i = 0; i < TYB; i++) begin
			ge_c[i]  = t_c[i] >= {1'b0, dn_c[i]};
			rem_c[i] = ge_c[i] ? SW'(t_c[i] - {1'b0, dn_c[i]}) : t_c[i][SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TYB; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < TYB; i++) v_q[i] <= v_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_q[0]   <= in_pix;
			oor_q[0] <= num >= den;
			for (int i = 1; i < TYB; i++) begin
				p_q[i]   <= p_q[i-1];
				oor_q[i] <= oor_q[i-1];
			end
			for (int i = 0; i < TYB; i++) begin
				den_q[i] <= dn_c[i];
				rem_q[i] <= rem_c[i];
				quo_q[i] <= TYB'({pq_c[i], ge_c[i]});
			end
		end
	end

	assign out_valid = v_q[TYB-1];
	assign out_pix   = p_q[TYB-1];
	assign ty        = quo_q[TYB-1];
	assign oor       = oor_q[TYB-1];
endmodule

/* rtl/textured_wall_column_shader.sv */
// Shades one raycaster wall pixel per clock. A beat with cmd 0 stores a texel; a beat
// with cmd 1 returns one pixel, ceiling, floor or texel color (zero when not drawn),
// through a 29-stage reciprocal for the wall height, one region stage, a 6-stage
// divider for the texel row, and the output stage where the texel memory read lands.
// Beats enter at one per cycle and shades leave at one per cycle; only output
// backpressure stalls the whole pipeline. Texel writes travel the pipeline in order
// with shades, so a write is seen by every later shade.
module textured_wall_column_shader import tws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data,
	tws_req_if.sink     req,
	tws_rsp_if.source   rsp
);
	logic [23:0] ceil_q, floor_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q  <= '0;
			floor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CEILING: ceil_q  <= cfg_data;
				CFG_FLOOR:   floor_q <= cfg_data;
			endcase
		end
	end

	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	meta_t in_meta;
	logic [23:0] hit;
	assign hit = (req.face < 2'd2) ? req.hit_x : req.hit_y;
	always_comb begin
		in_meta.cmd  = cmd_t'(req.cmd);
		in_meta.face = req.face;
		in_meta.tidx = req.texel_index;
		in_meta.tval = req.texel_value;
		in_meta.col  = req.column;
		in_meta.row  = req.row;
		in_meta.tx   = hit[SPB-1:SPB-TXB];
	end

	logic          vr;
	logic [QB-1:0] h8;
	meta_t         mr;

	tws_recip u_recip (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(req.valid), .d(req.distance), .in_meta(in_meta),
		.out_valid(vr), .h8(h8), .out_meta(mr)
	);

	logic [SW-1:0] s_c, bot_c;
	logic ceil_c, floor_c;
	pix_t pa_c;

	always_comb begin
		s_c     = SW'({mr.row, 9'b0}) + SW'(h8);
		bot_c   = (SW'(H0) + SW'(h8)) >> 9;
		ceil_c  = s_c < SW'(H0);
		floor_c = (SW'(mr.row) >= bot_c) || (h8 == '0);
		pa_c.m  = mr;
		if (ceil_c) begin
			pa_c.region = REG_CEIL;
		end else if (floor_c) begin
			pa_c.region = REG_FLOOR;
		end else begin
			pa_c.region = REG_WALL;
		end
		pa_c.onscr = ({1'b0, mr.col} < 11'(SCREEN_WIDTH)) &&
			({1'b0, mr.row} < 10'(SCREEN_HEIGHT));
	end

	logic          va_s1;
	pix_t          pa_s1;
	logic [SW-1:0] num_s1, den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s1 <= 1'b0;
		end else if (adv) begin
			va_s1 <= vr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1  <= pa_c;
			num_s1 <= s_c - SW'(H0);
			den_s1 <= {h8, 1'b0};
		end
	end

	logic           vt;
	logic [TYB-1:0] ty;
	logic           oor;
	pix_t           pt;

	tws_texrow u_texrow (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(va_s1), .num(num_s1), .den(den_s1), .in_pix(pa_s1),
		.out_valid(vt), .ty(ty), .oor(oor), .out_pix(pt)
	);

	logic          drawn_c, wr_c, rd_c;
	logic [AW-1:0] addr_c;
	logic [31:0]   rdata;

	always_comb begin
		drawn_c = pt.onscr && ((pt.region != REG_WALL) || !oor);
		wr_c    = adv && vt && (pt.m.cmd == CMD_WRITE) &&
			({1'b0, pt.m.tidx} < 13'(FACE_WORDS));
		rd_c    = adv && vt && (pt.m.cmd == CMD_SHADE) && (pt.region == REG_WALL) &&
			drawn_c;
		addr_c  = (pt.m.cmd == CMD_WRITE) ? {pt.m.face, pt.m.tidx[TXB+TYB-1:0]} :
			{pt.m.face, ty, pt.m.tx};
	end

	tws_ram #(.WIDTH(32), .DEPTH(TEX_DEPTH)) u_ram (
		.clk(clk), .en(wr_c || rd_c), .we(wr_c), .addr(addr_c),
		.wdata(pt.m.tval), .rdata(rdata)
	);

	logic        vo_s2, use_ram_s2, drawn_s2;
	logic [9:0]  col_s2;
	logic [8:0]  row_s2;
	region_t     reg_s2;
	logic [31:0] color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_s2 <= 1'b0;
		end else if (adv) begin
			vo_s2 <= vt && (pt.m.cmd == CMD_SHADE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s2     <= pt.m.col;
			row_s2     <= pt.m.row;
			reg_s2     <= pt.region;
			drawn_s2   <= drawn_c;
			use_ram_s2 <= drawn_c && (pt.region == REG_WALL);
			if (!drawn_c) begin
				color_s2 <= '0;
			end else if (pt.region == REG_CEIL) begin
				color_s2 <= {ceil_q, SHADE_ALPHA};
			end else begin
				color_s2 <= {floor_q, SHADE_ALPHA};
			end
		end
	end

	assign rsp.valid       = vo_s2;
	assign rsp.pixel_x     = col_s2;
	assign rsp.pixel_y     = row_s2;
	assign rsp.region      = reg_s2;
	assign rsp.drawn       = drawn_s2;
	assign rsp.pixel_color = use_ram_s2 ? rdata : color_s2;
endmodule

/* bench/tb_textured_wall_column_shader.sv */
module tb_textured_wall_column_shader;
	import tws_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  face;
		logic [11:0] tidx;
		logic [31:0] tval;
		logic [9:0]  col;
		logic [8:0]  row;
		logic [23:0] hx;
		logic [23:0] hy;
		logic [23:0] ray_dist;
	} beat_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [8:0]  y;
		logic [31:0] color;
		region_t     region;
		logic        drawn;
	} pixel_t;

	localparam int LIMIT = 2000000;
	localparam int LATENCY = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [23:0] cfg_data = '0;

	tws_req_if req ();
	tws_rsp_if rsp ();

	textured_wall_column_shader u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	always #6 clk = ~clk;

	beat_t pending_beats[$];
	pixel_t expected_pixels[$];
	logic [31:0] texels[TEX_DEPTH];
	bit written[TEX_DEPTH];
	logic [23:0] ceiling_rgb = '0, floor_rgb = '0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0, pixels_seen = 0, shades = 0, writes = 0;
	int cycles = 0;
	int region_hits[3] = '{0, 0, 0};

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic pixel_t shade_pixel(input beat_t b);
		pixel_t p;
		logic [63:0] h8, top9, bot9, y9, hit, tx, ty;
		logic [13:0] a;
		h8 = (b.ray_dist == 0) ? 64'(H0) : (64'(KNUM) / 64'(b.ray_dist));
		top9 = 64'(H0) - h8;
		bot9 = 64'(H0) + h8;
		y9 = 64'(b.row) * 512;
		p.x = b.col;
		p.y = b.row;
		if ($signed(y9) < $signed(top9)) p.region = REG_CEIL;
		else if (64'(b.row) >= (bot9 >> 9) || h8 == 0) p.region = REG_FLOOR;
		else p.region = REG_WALL;
		p.drawn = 1'b1;
		p.color = '0;
		if (b.col >= SCREEN_WIDTH || b.row >= SCREEN_HEIGHT) p.drawn = 1'b0;
		else if (p.region == REG_CEIL) p.color = {ceiling_rgb, SHADE_ALPHA};
		else if (p.region == REG_FLOOR) p.color = {floor_rgb, SHADE_ALPHA};
		else begin
			hit = (b.face < 2) ? 64'(b.hx) : 64'(b.hy);
			tx = ((hit % (TILE * 256)) * TEX_WIDTH) / (TILE * 256);
			ty = ((y9 - top9) * TEX_HEIGHT) / (2 * h8);
			if (tx >= TEX_WIDTH || ty >= TEX_HEIGHT) p.drawn = 1'b0;
			else begin
				a = 14'(64'(b.face) * FACE_WORDS + ty * TEX_WIDTH + tx);
				p.color = texels[a];
			end
		end
		return p;
	endfunction

	function automatic bit wall_texel_known(input beat_t b);
		logic [63:0] h8, top9, y9, hit, tx, ty;
		if (b.col >= SCREEN_WIDTH || b.row >= SCREEN_HEIGHT) return 1'b1;
		h8 = (b.ray_dist == 0) ? 64'(H0) : (64'(KNUM) / 64'(b.ray_dist));
		top9 = 64'(H0) - h8;
		y9 = 64'(b.row) * 512;
		if ($signed(y9) < $signed(top9) || 64'(b.row) >= ((64'(H0) + h8) >> 9) || h8 == 0)
			return 1'b1;
		hit = (b.face < 2) ? 64'(b.hx) : 64'(b.hy);
		tx = ((hit % (TILE * 256)) * TEX_WIDTH) / (TILE * 256);
		ty = ((y9 - top9) * TEX_HEIGHT) / (2 * h8);
		if (tx >= TEX_WIDTH || ty >= TEX_HEIGHT) return 1'b1;
		return written[14'(64'(b.face) * FACE_WORDS + ty * TEX_WIDTH + tx)];
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		b = beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		b.cmd = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_SHADE;
		if ($urandom_range(0, 1)) b.col = 10'($urandom_range(0, SCREEN_WIDTH - 1));
		case ($urandom_range(0, 5))
			0: b.ray_dist = '0;
			1: b.ray_dist = 24'($urandom_range(1, 255));
			2: b.ray_dist = 24'($urandom_range(256, 8192));
			3: b.ray_dist = 24'($urandom_range(8192, 200000));
			default: ;
		endcase
		return b;
	endfunction

	task automatic queue_beat(input beat_t b);
		if (b.cmd == CMD_SHADE && !wall_texel_known(b)) begin
			b.hx[SPB-1:SPB-TXB] = '0;
			b.hy[SPB-1:SPB-TXB] = '0;
		end
		if (b.cmd == CMD_SHADE && !wall_texel_known(b)) b.ray_dist = 24'hFFFFFF;
		pending_beats.push_back(b);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (pending_beats.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
					beat_t b;
					b = pending_beats.pop_front();
					req.valid <= 1'b1;
					{req.cmd, req.face, req.texel_index, req.texel_value, req.column, req.row,
						req.hit_x, req.hit_y, req.distance} <= b;
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= !hold_off && ($urandom_range(1, 100) > recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && req.valid && req.ready) begin
			beat_t b;
			b = {req.cmd, req.face, req.texel_index, req.texel_value, req.column, req.row,
				req.hit_x, req.hit_y, req.distance};
			if (b.cmd == CMD_WRITE) begin
				writes++;
				if (b.tidx < FACE_WORDS) begin
					texels[{b.face, b.tidx}] = b.tval;
					written[{b.face, b.tidx}] = 1'b1;
				end
			end else begin
				shades++;
				expected_pixels.push_back(shade_pixel(b));
			end
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			pixel_t want;
			pixels_seen++;
			if (expected_pixels.size() == 0) report("unexpected beat", 32'(rsp.pixel_x), '0);
			else begin
				want = expected_pixels.pop_front();
				if (rsp.pixel_x !== want.x)
					report("pixel_x", 32'(rsp.pixel_x), 32'(want.x));
				if (rsp.pixel_y !== want.y)
					report("pixel_y", 32'(rsp.pixel_y), 32'(want.y));
				if (rsp.pixel_color !== want.color)
					report("pixel_color", rsp.pixel_color, want.color);
				if (rsp.region !== want.region)
					report("region", 32'(rsp.region), 32'(want.region));
				if (rsp.drawn !== want.drawn)
					report("drawn", 32'(rsp.drawn), 32'(want.drawn));
				if (want.region <= REG_FLOOR) region_hits[want.region]++;
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() > 0 || req.valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CEILING) ceiling_rgb = value;
		else floor_rgb = value;
	endtask

	task automatic fill_textures();
		beat_t b;
		for (int f = 0; f < 4; f++)
			for (int r = 0; r < TEX_HEIGHT; r++) begin
				b = '0;
				b.cmd = CMD_WRITE;
				b.face = 2'(f);
				b.tidx = 12'(r * TEX_WIDTH);
				b.tval = (r % 2) ? 32'hFFFFFFFF : 32'h0;
				pending_beats.push_back(b);
			end
	endtask

	initial begin
		beat_t b;
		req.valid = 1'b0;
		{req.cmd, req.face, req.texel_index, req.texel_value, req.column, req.row,
			req.hit_x, req.hit_y, req.distance} = '0;
		rsp.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_reg(CFG_CEILING, 24'hFFFFFF);
		write_reg(CFG_FLOOR, 24'h000000);

		fill_textures();
		wait_drained();
		b = '0;
		b.cmd = CMD_SHADE;
		for (int k = 0; k < 20; k++) begin
			b.face = 2'(k % 4);
			b.col = (k % 3 == 0) ? 10'd1023 : 10'd0;
			b.row = (k % 5 == 0) ? 9'd511 : 9'(k * 25);
			b.hx = (k % 2) ? 24'hFFFFFF : 24'h0;
			b.hy = (k % 2) ? 24'h0 : 24'hFFFFFF;
			case (k % 4)
				0: b.ray_dist = '0;
				1: b.ray_dist = 24'hFFFFFF;
				2: b.ray_dist = 24'd256;
				default: b.ray_dist = 24'd6000;
			endcase
			queue_beat(b);
		end
		b = '0;
		b.cmd = CMD_WRITE;
		b.tidx = 12'hFFF;
		b.tval = 32'hDEADBEEF;
		b.face = 2'd3;
		pending_beats.push_back(b);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 65 : 0;
			recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 13 : 0;
			write_reg(CFG_CEILING, (phase == 2) ? 24'h0 : 24'($urandom));
			write_reg(CFG_FLOOR, (phase == 2) ? 24'hFFFFFF : 24'($urandom));
			for (int n = 0; n < 240; n++) queue_beat(random_beat());
			if (phase == 2) begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_drained();
		end

		$display("shaded %0d pixels (%0d beats out), %0d texel writes", shades, pixels_seen,
			writes);
		$display("ceiling %0d, wall %0d, floor %0d", region_hits[0], region_hits[1],
			region_hits[2]);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* sim.f */
rtl/tws_pkg.sv
rtl/tws_if.sv
rtl/tws_ram.sv
rtl/tws_recip.sv
rtl/tws_texrow.sv
rtl/textured_wall_column_shader.sv
bench/tb_textured_wall_column_shader.sv
